FILE: hw/rtl/lat_pkg.sv
// ----------------------------------------------------------------------------
// lat_pkg
// Shared types and constants of the toroidal Life step core.
// ----------------------------------------------------------------------------
`default_nettype none

package lat_pkg;

  localparam int unsigned SIDE_DEF = 64;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned ROW_W    = 6;
  localparam int unsigned CELL_W   = 64;
  localparam int unsigned GEN_W    = 16;

  localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADV  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ROW_W-1:0]  row;
    logic [CELL_W-1:0] cells;
    logic [GEN_W-1:0]  generations;
  } in_word_t;

  typedef struct packed {
    logic [ROW_W-1:0]  out_row;
    logic [CELL_W-1:0] out_cells;
    logic              step_done;
  } out_word_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lat_bank.sv
// ----------------------------------------------------------------------------
// lat_bank
// One board buffer: row memory with one write port, one registered read
// port and a valid bit per row so unwritten rows read as dead.
// ----------------------------------------------------------------------------
`default_nettype none

module lat_bank #(
  parameter int unsigned SIDE = 64,
  parameter int unsigned AW   = 6
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  logic [SIDE-1:0] wdata_i,
  input  logic            re_i,
  input  logic [AW-1:0]   raddr_i,
  output logic [SIDE-1:0] rdata_o
);

  logic [SIDE-1:0] mem [SIDE];
  logic [SIDE-1:0] vld_q;
  logic [SIDE-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= vld_q[raddr_i] ? mem[raddr_i] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (we_i) begin
      vld_q[waddr_i] <= 1'b1;
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hw/rtl/lat_rule.sv
// ----------------------------------------------------------------------------
// lat_rule
// Row evaluator: next state of one row from the rows above, at and below,
// B3/S23 with wrap at the left and right edges.
// ----------------------------------------------------------------------------
`default_nettype none

module lat_rule #(
  parameter int unsigned SIDE = 64
) (
  input  logic [SIDE-1:0] up_i,
  input  logic [SIDE-1:0] mid_i,
  input  logic [SIDE-1:0] dn_i,
  output logic [SIDE-1:0] nxt_o
);

  for (genvar c = 0; c < SIDE; c++) begin : g_col
    localparam int unsigned L = (c + SIDE - 1) % SIDE;
    localparam int unsigned R = (c + 1) % SIDE;
    logic [3:0] cnt;
    assign cnt = {3'b0, up_i[L]} + {3'b0, up_i[c]} + {3'b0, up_i[R]}
               + {3'b0, mid_i[L]} + {3'b0, mid_i[R]}
               + {3'b0, dn_i[L]} + {3'b0, dn_i[c]} + {3'b0, dn_i[R]};
    assign nxt_o[c] = (cnt == 4'd3) || (mid_i[c] && (cnt == 4'd2));
  end

endmodule

`default_nettype wire

FILE: hw/rtl/life_automaton_toroidal_step_core.sv
// ----------------------------------------------------------------------------
// life_automaton_toroidal_step_core
// Toroidal Life board (B3/S23), SIDE rows of SIDE cells, double-buffered.
//
// Input words (valid/ready): load a row, advance N generations, read a row.
// Output words (valid/ready): one per read (row and cells) and one per
// advance (step_done set, row and cells zero). Loads and unused kinds give
// no word.
// A read gives its word through the output register. An advance of N
// generations runs them in turn and then gives its completion word:
// each generation streams SIDE + 2 rows out of the current buffer
// through a three-row window, one row a cycle, and the single row
// evaluator writes one new row a cycle into the other buffer.
// The core takes one word at a time; ready is high only while it is idle.
// A finished result sits in an output register, so a stalled receiver
// blocks only the next read or advance from completing, not loads.
// Reset: both boards read as all dead and the first buffer is current;
// no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module life_automaton_toroidal_step_core #(
  parameter int unsigned SIDE = lat_pkg::SIDE_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lat_pkg::in_word_t in_word_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lat_pkg::out_word_t out_word_o
);

  import lat_pkg::*;

  localparam int unsigned AW = (SIDE > 1) ? $clog2(SIDE) : 1;
  localparam int unsigned CW = $clog2(SIDE + 4);

  localparam logic [CW-1:0] CNT_RD_LAST = CW'(SIDE + 1);
  localparam logic [CW-1:0] CNT_SH_LAST = CW'(SIDE + 2);
  localparam logic [CW-1:0] CNT_LAST    = CW'(SIDE + 3);
  localparam logic [CW-1:0] CNT_WR_1ST  = CW'(4);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_GEN  = 2'd1;
  localparam logic [1:0] ST_RD   = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]       state_q, state_d;
  logic             sel_q, sel_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [GEN_W-1:0] gens_q, gens_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             oor_q, oor_d;
  logic             out_vld_q, out_vld_d;
  out_word_t        out_q, out_d;
  logic [SIDE-1:0]  w_up_q, w_mid_q, w_dn_q;

  logic             acc;
  logic             in_range;
  logic             out_free;
  logic             shift;
  logic             we_any;
  logic             wr_dst;
  logic             tgt;
  logic [AW-1:0]    waddr;
  logic [SIDE-1:0]  wdata;
  logic             re;
  logic [AW-1:0]    raddr;
  logic [SIDE-1:0]  rd0, rd1, rd_cur;
  logic [SIDE-1:0]  nxt;
  logic [CW-1:0]    cnt_m1, cnt_m4;

  assign in_ready_o = (state_q == ST_IDLE);
  assign acc        = in_valid_i && in_ready_o;
  assign in_range   = {1'b0, in_word_i.row} < (ROW_W + 1)'(SIDE);
  assign out_free   = !out_vld_q || out_ready_i;
  assign rd_cur     = sel_q ? rd1 : rd0;
  assign cnt_m1     = cnt_q - CW'(1);
  assign cnt_m4     = cnt_q - CW'(4);
  assign tgt        = wr_dst ? !sel_q : sel_q;

  always_comb begin
    state_d   = state_q;
    sel_d     = sel_q;
    cnt_d     = cnt_q;
    gens_d    = gens_q;
    row_d     = row_q;
    oor_d     = oor_q;
    out_vld_d = out_vld_q && !out_ready_i;
    out_d     = out_q;
    shift     = 1'b0;
    we_any    = 1'b0;
    wr_dst    = 1'b0;
    waddr     = '0;
    wdata     = '0;
    re        = 1'b0;
    raddr     = '0;
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          case (in_word_i.kind)
            KIND_LOAD: begin
              if (in_range) begin
                we_any = 1'b1;
                waddr  = in_word_i.row[AW-1:0];
                wdata  = in_word_i.cells[SIDE-1:0];
              end
            end
            KIND_ADV: begin
              gens_d  = in_word_i.generations;
              cnt_d   = '0;
              state_d = (in_word_i.generations == '0) ? ST_DONE : ST_GEN;
            end
            KIND_READ: begin
              row_d   = in_word_i.row;
              oor_d   = !in_range;
              re      = in_range;
              raddr   = in_word_i.row[AW-1:0];
              state_d = ST_RD;
            end
            default: ;
          endcase
        end
      end
      ST_GEN: begin
        // issue rows SIDE-1, 0 .. SIDE-1, 0 into the window
        re = (cnt_q <= CNT_RD_LAST);
        if (cnt_q == '0) begin
          raddr = AW'(SIDE - 1);
        end else if (cnt_q == CNT_RD_LAST) begin
          raddr = '0;
        end else begin
          raddr = cnt_m1[AW-1:0];
        end
        shift = (cnt_q != '0) && (cnt_q <= CNT_SH_LAST);
        if (cnt_q >= CNT_WR_1ST) begin
          we_any = 1'b1;
          wr_dst = 1'b1;
          waddr  = cnt_m4[AW-1:0];
          wdata  = nxt;
        end
        if (cnt_q == CNT_LAST) begin
          sel_d = !sel_q;
          cnt_d = '0;
          if (gens_q == GEN_W'(1)) begin
            state_d = ST_DONE;
          end else begin
            gens_d = gens_q - GEN_W'(1);
          end
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      ST_RD: begin
        if (out_free) begin
          out_vld_d         = 1'b1;
          out_d.out_row     = row_q;
          out_d.out_cells   = oor_q ? '0 : CELL_W'(rd_cur);
          out_d.step_done   = 1'b0;
          state_d           = ST_IDLE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_vld_d         = 1'b1;
          out_d.out_row     = '0;
          out_d.out_cells   = '0;
          out_d.step_done   = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      sel_q     <= 1'b0;
      cnt_q     <= '0;
      gens_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      sel_q     <= sel_d;
      cnt_q     <= cnt_d;
      gens_q    <= gens_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q <= row_d;
    oor_q <= oor_d;
    out_q <= out_d;
    if (shift) begin
      w_up_q  <= w_mid_q;
      w_mid_q <= w_dn_q;
      w_dn_q  <= rd_cur;
    end
  end

  lat_bank #(.SIDE(SIDE), .AW(AW)) u_bank0 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (we_any && !tgt),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rd0)
  );

  lat_bank #(.SIDE(SIDE), .AW(AW)) u_bank1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (we_any && tgt),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rd1)
  );

  lat_rule #(.SIDE(SIDE)) u_rule (
    .up_i  (w_up_q),
    .mid_i (w_mid_q),
    .dn_i  (w_dn_q),
    .nxt_o (nxt)
  );

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

  a_gen_no_cur_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_GEN && we_any) |-> wr_dst)
    else $error("current board written during a generation");

  a_gen_write_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_GEN && we_any) |-> (cnt_q >= CNT_WR_1ST))
    else $error("row written before the window is filled");

  a_swap_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sel_q != sel_d) |-> (state_q == ST_GEN && cnt_q == CNT_LAST))
    else $error("board swap outside the end of a generation");

  a_done_word_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.step_done) |-> (out_q.out_row == '0 && out_q.out_cells == '0))
    else $error("completion word carries row data");

  a_out_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_RD || state_q == ST_DONE) && out_vld_q && !out_ready_i)
      |=> (state_q == $past(state_q)))
    else $error("result dropped while output stalled");

endmodule

`default_nettype wire

FILE: test/life_step_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_step_checker
// Watches both channels of the toroidal Life step core. Keeps its own pair of
// boards, predicts the output word of every accepted read or advance, and
// compares each delivered word field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module life_step_checker #(
  parameter int unsigned SIDE = lat_pkg::SIDE_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  lat_pkg::in_word_t  in_word_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  lat_pkg::out_word_t out_word_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  import lat_pkg::*;

  typedef logic [CELL_W-1:0] row_t;

  localparam row_t LIVE_MASK = (SIDE >= CELL_W) ? '1 : row_t'((64'd1 << SIDE) - 64'd1);

  row_t      boards [2][SIDE];
  logic      cur_sel;
  out_word_t awaited_words [$];
  int        fails = 0;
  int        awaiting = 0;

  assign fail_count_o = fails;
  assign pending_o    = awaiting;

  // column c-1 moved into column c, wrapping
  function automatic row_t wrap_from_left(row_t r);
    return ((r << 1) | (r >> (SIDE - 1))) & LIVE_MASK;
  endfunction

  // column c+1 moved into column c, wrapping
  function automatic row_t wrap_from_right(row_t r);
    return ((r >> 1) | ((r & row_t'(1)) << (SIDE - 1))) & LIVE_MASK;
  endfunction

  function automatic row_t life_next_row(row_t above, row_t mid, row_t below);
    row_t nb [8];
    row_t cnt0, cnt1, cnt2, carry0, carry1;
    int   k;
    nb[0] = wrap_from_left(above);
    nb[1] = above;
    nb[2] = wrap_from_right(above);
    nb[3] = wrap_from_left(mid);
    nb[4] = wrap_from_right(mid);
    nb[5] = wrap_from_left(below);
    nb[6] = below;
    nb[7] = wrap_from_right(below);
    cnt0 = '0;
    cnt1 = '0;
    cnt2 = '0;
    for (k = 0; k < 8; k++) begin
      carry0 = cnt0 & nb[k];
      cnt0   = cnt0 ^ nb[k];
      carry1 = cnt1 & carry0;
      cnt1   = cnt1 ^ carry0;
      cnt2   = cnt2 ^ carry1;
    end
    return ~cnt2 & cnt1 & (cnt0 | mid) & LIVE_MASK;
  endfunction

  task automatic advance_board(int unsigned gens);
    int unsigned g, r, up, dn;
    for (g = 0; g < gens; g++) begin
      for (r = 0; r < SIDE; r++) begin
        up = (r == 0) ? SIDE - 1 : r - 1;
        dn = (r == SIDE - 1) ? 0 : r + 1;
        boards[~cur_sel][r] = life_next_row(boards[cur_sel][up], boards[cur_sel][r],
                                            boards[cur_sel][dn]);
      end
      cur_sel = ~cur_sel;
    end
  endtask

  task automatic take_command(in_word_t w);
    out_word_t res;
    case (w.kind)
      KIND_LOAD: begin
        if (w.row < SIDE) boards[cur_sel][w.row] = w.cells & LIVE_MASK;
      end
      KIND_ADV: begin
        advance_board(32'(w.generations));
        res.out_row   = '0;
        res.out_cells = '0;
        res.step_done = 1'b1;
        awaited_words.push_back(res);
      end
      KIND_READ: begin
        res.out_row   = w.row;
        res.out_cells = (w.row < SIDE) ? boards[cur_sel][w.row] : '0;
        res.step_done = 1'b0;
        awaited_words.push_back(res);
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_word(out_word_t got);
    out_word_t want;
    if (awaited_words.size() == 0) begin
      $error("unexpected word: out_row %0d out_cells %h step_done %0b",
             got.out_row, got.out_cells, got.step_done);
      fails++;
    end else begin
      want = awaited_words.pop_front();
      if (got.out_row !== want.out_row) begin
        $error("out_row: expected %0d, actual %0d", want.out_row, got.out_row);
        fails++;
      end
      if (got.out_cells !== want.out_cells) begin
        $error("out_cells: expected %h, actual %h", want.out_cells, got.out_cells);
        fails++;
      end
      if (got.step_done !== want.step_done) begin
        $error("step_done: expected %0b, actual %0b", want.step_done, got.step_done);
        fails++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < SIDE; r++) begin
        boards[0][r] = '0;
        boards[1][r] = '0;
      end
      cur_sel = 1'b0;
      awaited_words.delete();
      awaiting = 0;
    end else begin
      if (in_valid_i && in_ready_i) take_command(in_word_i);
      if (out_valid_i && out_ready_i) check_word(out_word_i);
      awaiting = awaited_words.size();
    end
  end

endmodule

FILE: test/life_automaton_toroidal_step_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_automaton_toroidal_step_core_tb
// Drives loads, advances and reads into the toroidal Life step core with
// random gaps on the input and random stalls on the output, and lets the
// board checker predict and compare every output word.
// ----------------------------------------------------------------------------
module life_automaton_toroidal_step_core_tb;
  import lat_pkg::*;

  localparam int unsigned SIDE         = SIDE_DEF;
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 800;
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned TAIL_CYCLES  = 2 * SIDE + 8;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_word;
  int        fail_count;
  int        pending;
  bit        calm = 1'b0;
  int        sent = 0;
  int        cycles = 0;

  life_automaton_toroidal_step_core #(.SIDE(SIDE)) uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word)
  );

  life_step_checker #(.SIDE(SIDE)) board_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_word_i    (in_word),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_word_i   (out_word),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic logic [CELL_W-1:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [CELL_W-1:0] pick_cells();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return rand64() & rand64() & rand64();
      3, 4: return rand64() & rand64();
      5: return 64'd1 << $urandom_range(0, CELL_W - 1);
      default: return rand64();
    endcase
  endfunction

  function automatic int unsigned pick_generations();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 70) return $urandom_range(0, 2);
    if (p < 95) return $urandom_range(3, 6);
    return $urandom_range(7, 16);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned p;
    if (calm) return 0;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned any_row();
    return $urandom_range(0, (1 << ROW_W) - 1);
  endfunction

  // present one word at the falling edge, hold until taken
  task automatic send_word(logic [KIND_W-1:0] kind, logic [ROW_W-1:0] row,
                           logic [CELL_W-1:0] cells, logic [GEN_W-1:0] gens);
    in_word_t    w;
    int unsigned gap;
    w.kind        = kind;
    w.row         = row;
    w.cells       = cells;
    w.generations = gens;
    in_word  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic load_row(int unsigned row, logic [CELL_W-1:0] cells);
    send_word(KIND_LOAD, ROW_W'(row), cells, GEN_W'($urandom_range(0, 65535)));
    sent++;
  endtask

  task automatic read_row(int unsigned row);
    send_word(KIND_READ, ROW_W'(row), rand64(), GEN_W'($urandom_range(0, 65535)));
    sent++;
  endtask

  task automatic run_generations(int unsigned gens);
    send_word(KIND_ADV, ROW_W'(any_row()), rand64(), GEN_W'(gens));
    sent++;
  endtask

  initial begin : rx_side
    int unsigned hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) hold = pick_gap();
      end
    end
  end

  initial begin : stimulus
    int unsigned pick, n, base, i;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    read_row(0);
    read_row(SIDE - 1);
    send_word(KIND_LOAD, ROW_W'(0), '1, 16'hFFFF);
    send_word(KIND_LOAD, ROW_W'(SIDE - 1), 64'h8000_0000_0000_0001, 16'h0000);
    read_row(0);
    read_row(SIDE - 1);
    run_generations(0);
    read_row(0);
    send_word(KIND_SPARE, '1, '1, '1);
    read_row(SIDE - 1);
    // glider straddling both wrap edges
    load_row(SIDE - 2, 64'h1);
    load_row(SIDE - 1, 64'h2);
    load_row(0, (64'h1 << (SIDE - 1)) | 64'h3);
    run_generations(1);
    read_row(SIDE - 2);
    read_row(SIDE - 1);
    read_row(0);
    read_row(1);
    run_generations(4 * SIDE - 1);
    read_row(SIDE - 2);
    read_row(SIDE - 1);
    read_row(0);
    load_row(SIDE / 2, '1);
    run_generations(2);
    read_row(SIDE / 2 - 1);
    read_row(SIDE / 2);
    read_row(SIDE / 2 + 1);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 6) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 58) begin
        n    = $urandom_range(1, 8);
        base = $urandom_range(0, SIDE - 1);
        for (i = 0; i < n; i++) load_row((base + i) % SIDE, pick_cells());
        run_generations(pick_generations());
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++) read_row((base + $urandom_range(0, 9) + SIDE - 1) % SIDE);
      end else if (pick < 78) begin
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++) read_row(any_row());
      end else if (pick < 81) begin
        for (i = 0; i < SIDE; i++) load_row(i, pick_cells());
        run_generations(pick_generations());
        read_row(any_row());
        read_row(any_row());
      end else if (pick < 91) begin
        n = $urandom_range(1, 3);
        for (i = 0; i < n; i++) run_generations(pick_generations());
        read_row(any_row());
      end else begin
        n = $urandom_range(1, 3);
        for (i = 0; i < n; i++) send_word(KIND_SPARE, ROW_W'(any_row()), rand64(),
                                          GEN_W'($urandom_range(0, 65535)));
        run_generations(0);
        load_row(any_row(), rand64());
      end
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
